[src/cmhd_pkg.sv]
// ----------------------------------------------------------------------------
// cmhd_pkg: shared types and constants
// Beat formats, action codes and defaults for the constellation map and hard
// demap core.
// ----------------------------------------------------------------------------
package cmhd_pkg;

    localparam int MAX_POINTS_DEF = 16;
    localparam int LABEL_BITS_DEF = 8;

    localparam int CFG_W  = 5;
    localparam int SAMP_W = 16;
    localparam int LBL_W  = 8;
    localparam int IDX_W  = 4;
    localparam int DIST_W = 18;

    localparam logic [CFG_W-1:0] POINTS_RESET = 5'd16;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_MAP   = 2'd1;
    localparam logic [1:0] ACT_DEMAP = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    typedef struct packed {
        logic [1:0]               action;
        logic [IDX_W-1:0]         entry_index;
        logic signed [SAMP_W-1:0] in_re;
        logic signed [SAMP_W-1:0] in_im;
        logic [LBL_W-1:0]         in_label;
    } cmhd_in_t;

    typedef struct packed {
        logic signed [SAMP_W-1:0] out_re;
        logic signed [SAMP_W-1:0] out_im;
        logic [LBL_W-1:0]         out_label;
        logic                     no_match;
    } cmhd_out_t;

    // Item as it travels along the cell chain, with the partial search result.
    typedef struct packed {
        logic [1:0]               action;
        logic [IDX_W-1:0]         entry_index;
        logic signed [SAMP_W-1:0] re;
        logic signed [SAMP_W-1:0] im;
        logic [LBL_W-1:0]         label;
        logic                     found;
        logic signed [SAMP_W-1:0] res_re;
        logic signed [SAMP_W-1:0] res_im;
        logic [DIST_W-1:0]        best_dist;
        logic [LBL_W-1:0]         best_label;
    } cmhd_tok_t;

endpackage

[src/cmhd_cell.sv]
// ----------------------------------------------------------------------------
// cmhd_cell: one constellation point cell
// Holds one table entry and updates the passing beat: stores the point on a
// matching load, records the first label match, and keeps the nearest point.
// ----------------------------------------------------------------------------
module cmhd_cell #(
    parameter int INDEX      = 0,
    parameter int LABEL_BITS = cmhd_pkg::LABEL_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 active,
    input  logic                 prev_valid,
    input  cmhd_pkg::cmhd_tok_t  prev_tok,
    output logic                 valid,
    output cmhd_pkg::cmhd_tok_t  tok
);
    import cmhd_pkg::*;

    logic signed [SAMP_W-1:0] pt_re_reg;
    logic signed [SAMP_W-1:0] pt_im_reg;
    logic [LABEL_BITS-1:0]    pt_label_reg;

    logic                     valid_reg;
    cmhd_tok_t                tok_reg;
    cmhd_tok_t                tok_next;

    logic signed [SAMP_W:0]   d_re;
    logic signed [SAMP_W:0]   d_im;
    logic [SAMP_W:0]          a_re;
    logic [SAMP_W:0]          a_im;
    logic [DIST_W-1:0]        man_dist;
    logic                     load_hit;

    assign d_re = {prev_tok.re[SAMP_W-1], prev_tok.re} - {pt_re_reg[SAMP_W-1], pt_re_reg};
    assign d_im = {prev_tok.im[SAMP_W-1], prev_tok.im} - {pt_im_reg[SAMP_W-1], pt_im_reg};
    assign a_re = d_re[SAMP_W] ? (SAMP_W+1)'(-d_re) : d_re;
    assign a_im = d_im[SAMP_W] ? (SAMP_W+1)'(-d_im) : d_im;
    assign man_dist = DIST_W'(a_re) + DIST_W'(a_im);

    assign load_hit = prev_valid && (prev_tok.action == ACT_LOAD)
                      && (32'(prev_tok.entry_index) == INDEX);

    always_comb
    begin
        tok_next = prev_tok;
        case (prev_tok.action)
            ACT_MAP:
            begin
                if (active && !prev_tok.found
                    && (prev_tok.label[LABEL_BITS-1:0] == pt_label_reg))
                begin
                    tok_next.found  = 1'b1;
                    tok_next.res_re = pt_re_reg;
                    tok_next.res_im = pt_im_reg;
                end
            end
            ACT_DEMAP:
            begin
                // The first cell seeds the search; later cells replace only on
                // a strictly smaller distance, so the lowest index wins a tie.
                if ((INDEX == 0) || (active && (man_dist < prev_tok.best_dist)))
                begin
                    tok_next.best_dist  = man_dist;
                    tok_next.best_label = LBL_W'(pt_label_reg);
                end
            end
            default:
            begin
                tok_next = prev_tok;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tok_reg <= tok_next;
            if (load_hit)
            begin
                pt_re_reg    <= prev_tok.re;
                pt_im_reg    <= prev_tok.im;
                pt_label_reg <= prev_tok.label[LABEL_BITS-1:0];
            end
        end
    end

    assign valid = valid_reg;
    assign tok   = tok_reg;

endmodule

[src/constellation_map_and_hard_demap_core.sv]
// ----------------------------------------------------------------------------
// constellation_map_and_hard_demap_core: constellation map and hard demapper
// Point table held in a chain of cells; map and nearest-point demap items
// sweep the chain one cell per cycle while the chain is not stalled.
// ----------------------------------------------------------------------------
// An input beat is registered in each cell of the chain in turn and then in
// the output register before its result beat appears.
// Throughput: one item per cycle while out_ready stays high; the cell chain is
// a pipeline; a full output register with out_ready low stalls the whole chain.
// Reset: rst_n clears all valid flags and sets points_in_use to 16; table
// entries are undefined until loaded.
module constellation_map_and_hard_demap_core #(
    parameter int MAX_POINTS = cmhd_pkg::MAX_POINTS_DEF,
    parameter int LABEL_BITS = cmhd_pkg::LABEL_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  cmhd_pkg::cmhd_in_t             in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output cmhd_pkg::cmhd_out_t            out_data,
    input  logic                           cfg_we,
    input  logic [cmhd_pkg::CFG_W-1:0]     cfg_wdata
);
    import cmhd_pkg::*;

    // The configured point count. Values below two behave as two because
    // cells zero and one are always searched; values above the table size
    // simply enable every cell there is.
    logic [CFG_W-1:0]  points_in_use_reg;

    // Chain links: link 0 is the input beat, link k is the output of cell k-1.
    logic              link_valid [0:MAX_POINTS];
    cmhd_tok_t         link_tok   [0:MAX_POINTS];
    logic              cell_active [0:MAX_POINTS-1];

    logic              adv;
    logic              out_valid_reg;
    logic              out_valid_next;
    cmhd_out_t         out_data_reg;
    cmhd_out_t         out_data_next;
    cmhd_tok_t         last_tok;
    cmhd_tok_t         in_tok;
    logic [LBL_W-1:0]  label_mask;

    // The whole chain moves together; it only holds when a finished result
    // is still waiting in the output register.
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    assign label_mask = LBL_W'((9'd1 << LABEL_BITS) - 9'd1);

    always_comb
    begin
        in_tok             = '0;
        in_tok.action      = in_data.action;
        in_tok.entry_index = in_data.entry_index;
        in_tok.re          = in_data.in_re;
        in_tok.im          = in_data.in_im;
        in_tok.label       = in_data.in_label & label_mask;
    end

    assign link_valid[0] = in_valid;
    assign link_tok[0]   = in_tok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            points_in_use_reg <= POINTS_RESET;
        end
        else if (cfg_we)
        begin
            points_in_use_reg <= cfg_wdata;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_POINTS; gi++)
        begin : g_cell
            if (gi < 2)
            begin : g_always
                assign cell_active[gi] = 1'b1;
            end
            else
            begin : g_cfg
                assign cell_active[gi] = 32'(points_in_use_reg) > gi;
            end

            cmhd_cell #(
                .INDEX      (gi),
                .LABEL_BITS (LABEL_BITS)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .adv        (adv),
                .active     (cell_active[gi]),
                .prev_valid (link_valid[gi]),
                .prev_tok   (link_tok[gi]),
                .valid      (link_valid[gi+1]),
                .tok        (link_tok[gi+1])
            );
        end
    endgenerate

    assign last_tok = link_tok[MAX_POINTS];

    // Format the result beat. Loads and the unused action leave the chain
    // without producing a result.
    always_comb
    begin
        out_data_next  = '0;
        out_valid_next = 1'b0;
        unique case (last_tok.action)
            ACT_MAP:
            begin
                out_valid_next = link_valid[MAX_POINTS];
                if (last_tok.found)
                begin
                    out_data_next.out_re = last_tok.res_re;
                    out_data_next.out_im = last_tok.res_im;
                end
                out_data_next.no_match = !last_tok.found;
            end
            ACT_DEMAP:
            begin
                out_valid_next          = link_valid[MAX_POINTS];
                out_data_next.out_label = last_tok.best_label;
            end
            ACT_LOAD, ACT_NONE:
            begin
                out_valid_next = 1'b0;
            end
            default:
            begin
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The chain only ever holds because a result beat is waiting downstream.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("chain stalled without a waiting result beat");

    // A waiting result beat is neither lost nor changed.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("result beat changed while stalled");

    // A demap result carries no point and no flag.
    a_demap_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.out_label != '0)) |->
            (out_data.out_re == '0 && out_data.out_im == '0 && !out_data.no_match))
        else $error("demap result carries map fields");

    // A failed map returns a zero point.
    a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.no_match) |->
            (out_data.out_re == '0 && out_data.out_im == '0 && out_data.out_label == '0))
        else $error("no-match result carries a point");

endmodule
